/* hw/rtl/eadc_pkg.sv */
// Shared types and constants for the echo average distance classifier.
// Used by eadc_band_classifier and the top level; no dependencies.
package eadc_pkg;

	// Echo time per centimetre of distance, in microseconds
	localparam logic [5:0] US_PER_CM = 6'd58;

	// Eight-band thresholds in microseconds (40 cm down to 10 cm in 5 cm steps)
	localparam logic [15:0] EIGHT_FAR_US  = 16'd2320;
	localparam logic [15:0] EIGHT_B1_US   = 16'd2030;
	localparam logic [15:0] EIGHT_B2_US   = 16'd1740;
	localparam logic [15:0] EIGHT_B3_US   = 16'd1450;
	localparam logic [15:0] EIGHT_B4_US   = 16'd1160;
	localparam logic [15:0] EIGHT_B5_US   = 16'd870;
	localparam logic [15:0] EIGHT_B6_US   = 16'd580;

	// Distance codes
	localparam logic [2:0] CODE_FAR      = 3'd0;
	localparam logic [2:0] CODE_BAND1    = 3'd1;
	localparam logic [2:0] CODE_BAND2    = 3'd2;
	localparam logic [2:0] CODE_BAND3    = 3'd3;
	localparam logic [2:0] CODE_BAND4    = 3'd4;
	localparam logic [2:0] CODE_BAND5    = 3'd5;
	localparam logic [2:0] CODE_BAND6    = 3'd6;
	localparam logic [2:0] CODE_NEAREST  = 3'd7;

	// Register indexes (byte address = 4 * index)
	typedef enum logic [1:0] {
		REG_BAND_MODE = 2'd0,
		REG_FAR_LIMIT = 2'd1,
		REG_MID_LIMIT = 2'd2,
		REG_NEAR_LIMIT = 2'd3
	} reg_idx_t;

	// Configuration as seen by the classifier
	typedef struct packed {
		logic       band_mode;
		logic [7:0] far_limit_cm;
		logic [7:0] mid_limit_cm;
		logic [7:0] near_limit_cm;
	} band_cfg_t;

endpackage

/* hw/rtl/eadc_band_classifier.sv */
// Distance band classifier: maps a mean echo width to a 3-bit distance code.
// Depends on eadc_pkg for thresholds, codes and the configuration struct.
module eadc_band_classifier
	import eadc_pkg::*;
(
	input  logic [15:0] mean_width,
	input  band_cfg_t   cfg,
	output logic [2:0]  level_code
);

	logic [15:0] far_us;
	logic [15:0] mid_us;
	logic [15:0] near_us;
	logic [2:0]  three_code;
	logic [2:0]  eight_code;

	// Configured limits scaled to microseconds (at most 14790, fits 16 bits)
	assign far_us  = 16'(cfg.far_limit_cm)  * 16'(US_PER_CM);
	assign mid_us  = 16'(cfg.mid_limit_cm)  * 16'(US_PER_CM);
	assign near_us = 16'(cfg.near_limit_cm) * 16'(US_PER_CM);

	// Three-band: tests in fixed order, first match wins, no sorting of limits
	always_comb begin
		if (mean_width < far_us && mean_width >= mid_us) begin
			three_code = CODE_BAND4;
		end else if (mean_width < mid_us && mean_width >= near_us) begin
			three_code = CODE_BAND6;
		end else if (mean_width < near_us) begin
			three_code = CODE_NEAREST;
		end else begin
			three_code = CODE_FAR;
		end
	end

	// Eight-band: fixed ladder from far to near
	always_comb begin
		if (mean_width >= EIGHT_FAR_US) begin
			eight_code = CODE_FAR;
		end else if (mean_width >= EIGHT_B1_US) begin
			eight_code = CODE_BAND1;
		end else if (mean_width >= EIGHT_B2_US) begin
			eight_code = CODE_BAND2;
		end else if (mean_width >= EIGHT_B3_US) begin
			eight_code = CODE_BAND3;
		end else if (mean_width >= EIGHT_B4_US) begin
			eight_code = CODE_BAND4;
		end else if (mean_width >= EIGHT_B5_US) begin
			eight_code = CODE_BAND5;
		end else if (mean_width >= EIGHT_B6_US) begin
			eight_code = CODE_BAND6;
		end else begin
			eight_code = CODE_NEAREST;
		end
	end

	assign level_code = cfg.band_mode ? three_code : eight_code;

endmodule

/* hw/rtl/echo_average_distance_classifier.sv */
// Echo average distance classifier: running mean of the last WINDOW_LEN echo
// widths plus a 3-bit distance code. Each accepted request passes the sum update at
// accept, then the reciprocal multiply, then classify into the result register;
// one request per cycle is sustained, only a stalled result holds the pipeline.
// Async active-low reset clears the window, the running sum and the pipeline
// valids, and loads the register defaults. Depends on eadc_pkg, eadc_band_classifier.
module echo_average_distance_classifier
	import eadc_pkg::*;
#(
	parameter int WINDOW_LEN = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// echo request channel
	input  logic        echo_valid,
	output logic        echo_stall,
	input  logic [15:0] echo_width,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] mean_width,
	output logic [2:0]  level_code
);

	// Sum width and reciprocal for an exact divide by WINDOW_LEN
	localparam int LOG_N   = $clog2(WINDOW_LEN);
	localparam int SUM_W   = 16 + LOG_N;
	localparam int SHIFT   = SUM_W + LOG_N;
	localparam int RECIP_W = SUM_W + 2;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

	band_cfg_t         cfg_q;
	reg_idx_t          reg_idx;
	logic              cfg_write;

	logic [15:0]       taps_q [WINDOW_LEN];
	logic [SUM_W-1:0]  sum_q;
	logic              valid_s1;
	logic              valid_s2;
	logic [15:0]       mean_s2;
	logic              result_valid_q;
	logic [15:0]       mean_q;
	logic [2:0]        code_q;

	logic              out_load;
	logic              load_s2;
	logic              load_s1;
	logic              accept;
	logic [PROD_W-1:0] prod;
	logic [2:0]        code;

	// Configuration registers
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_idx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_mode     <= 1'b0;
			cfg_q.far_limit_cm  <= 8'd20;
			cfg_q.mid_limit_cm  <= 8'd15;
			cfg_q.near_limit_cm <= 8'd10;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_BAND_MODE:  cfg_q.band_mode     <= pwdata[0];
				REG_FAR_LIMIT:  cfg_q.far_limit_cm  <= pwdata[7:0];
				REG_MID_LIMIT:  cfg_q.mid_limit_cm  <= pwdata[7:0];
				REG_NEAR_LIMIT: cfg_q.near_limit_cm <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (reg_idx)
			REG_BAND_MODE:  prdata = {31'd0, cfg_q.band_mode};
			REG_FAR_LIMIT:  prdata = {24'd0, cfg_q.far_limit_cm};
			REG_MID_LIMIT:  prdata = {24'd0, cfg_q.mid_limit_cm};
			REG_NEAR_LIMIT: prdata = {24'd0, cfg_q.near_limit_cm};
			default:        prdata = 32'd0;
		endcase
	end

	// Pipeline flow control: a stage loads when it is empty or moving on
	assign out_load   = !result_valid_q || !result_stall;
	assign load_s2    = !valid_s2 || out_load;
	assign load_s1    = !valid_s1 || load_s2;
	assign echo_stall = !load_s1;
	assign accept     = echo_valid && load_s1;

	// Stage 1: window shift line and running sum (sum_q is the stage payload)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				taps_q[i] <= 16'd0;
			end
			sum_q <= '0;
		end else if (accept) begin
			taps_q[0] <= echo_width;
			for (int i = 1; i < WINDOW_LEN; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
			sum_q <= sum_q - SUM_W'(taps_q[WINDOW_LEN-1]) + SUM_W'(echo_width);
		end
	end

	// Stage 2: divide by WINDOW_LEN through the rounded-up reciprocal
	assign prod = PROD_W'(sum_q) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			mean_s2 <= prod[SHIFT +: 16];
		end
	end

	// Stage 3: classify into the result register
	eadc_band_classifier u_classifier (
		.mean_width (mean_s2),
		.cfg        (cfg_q),
		.level_code (code)
	);

	always_ff @(posedge clk) begin
		if (out_load && valid_s2) begin
			mean_q <= mean_s2;
			code_q <= code;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= echo_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (out_load) begin
				result_valid_q <= valid_s2;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign mean_width   = mean_q;
	assign level_code   = code_q;

	// Checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request did not reach stage 1");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		echo_stall |-> (valid_s1 && valid_s2 && result_valid_q))
		else $error("input stalled with a free pipeline slot");

	a_eight_band_far: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !cfg_q.band_mode) |->
			((level_code == CODE_FAR) == (mean_width >= EIGHT_FAR_US)))
		else $error("eight-band far code disagrees with mean");

	a_result_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s2))
		else $error("result appeared without a stage 2 request");

endmodule

/* tb/sv/eadc_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the echo average distance classifier: follows register writes
// and accepted echo requests, predicts mean and distance code, compares results.
// Depends on eadc_pkg.
module eadc_result_checker
	import eadc_pkg::*;
#(
	parameter int WINDOW_LEN = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        echo_valid,
	input  logic        echo_stall,
	input  logic [15:0] echo_width,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [15:0] mean_width,
	input  logic [2:0]  level_code,
	output int          fail_count,
	output int          pending,
	output int          checked
);

	localparam int SUM_W = 16 + $clog2(WINDOW_LEN);

	typedef struct packed {
		logic [15:0] mean;
		logic [2:0]  code;
	} mean_code_t;

	// Model state: sliding window, running sum, write slot, loaded limits
	logic [15:0]      width_hist [WINDOW_LEN];
	logic [SUM_W-1:0] width_sum;
	int unsigned      wr_slot;
	band_cfg_t        limits;
	mean_code_t       mean_code_queue [$];

	// Distance code for a mean width under the given limits
	function automatic logic [2:0] classify_mean(logic [15:0] m, band_cfg_t c);
		logic [15:0] far_us;
		logic [15:0] mid_us;
		logic [15:0] near_us;
		far_us  = 16'(c.far_limit_cm) * 16'(US_PER_CM);
		mid_us  = 16'(c.mid_limit_cm) * 16'(US_PER_CM);
		near_us = 16'(c.near_limit_cm) * 16'(US_PER_CM);
		if (c.band_mode) begin
			// tests in fixed order, no sorting of the limits
			if (m < far_us && m >= mid_us) return CODE_BAND4;
			if (m < mid_us && m >= near_us) return CODE_BAND6;
			if (m < near_us) return CODE_NEAREST;
			return CODE_FAR;
		end
		if (m >= EIGHT_FAR_US) return CODE_FAR;
		if (m >= EIGHT_B1_US) return CODE_BAND1;
		if (m >= EIGHT_B2_US) return CODE_BAND2;
		if (m >= EIGHT_B3_US) return CODE_BAND3;
		if (m >= EIGHT_B4_US) return CODE_BAND4;
		if (m >= EIGHT_B5_US) return CODE_BAND5;
		if (m >= EIGHT_B6_US) return CODE_BAND6;
		return CODE_NEAREST;
	endfunction

	// Slide one width into the window and queue the mean and code it yields
	task automatic predict_mean_and_code(logic [15:0] w);
		mean_code_t r;
		width_sum = width_sum - width_hist[wr_slot] + w;
		width_hist[wr_slot] = w;
		wr_slot = (wr_slot == WINDOW_LEN - 1) ? 0 : wr_slot + 1;
		r.mean = 16'(width_sum / WINDOW_LEN);
		r.code = classify_mean(r.mean, limits);
		mean_code_queue.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) width_hist[i] = '0;
			width_sum = '0;
			wr_slot = 0;
			limits.band_mode = 1'b0;
			limits.far_limit_cm = 8'd20;
			limits.mid_limit_cm = 8'd15;
			limits.near_limit_cm = 8'd10;
			mean_code_queue.delete();
			fail_count = 0;
			checked = 0;
		end else begin
			// register write lands at the access cycle; low bits only
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_BAND_MODE:  limits.band_mode = pwdata[0];
					REG_FAR_LIMIT:  limits.far_limit_cm = pwdata[7:0];
					REG_MID_LIMIT:  limits.mid_limit_cm = pwdata[7:0];
					REG_NEAR_LIMIT: limits.near_limit_cm = pwdata[7:0];
					default: ;
				endcase
			end
			// accepted result against the oldest expectation
			if (result_valid && !result_stall) begin
				if (mean_code_queue.size() == 0) begin
					fail_count++;
					$display("%0t: expected no result, got mean_width=%0d level_code=%0d",
						$time, mean_width, level_code);
				end else begin
					mean_code_t exp_r;
					exp_r = mean_code_queue.pop_front();
					checked++;
					if (mean_width !== exp_r.mean) begin
						fail_count++;
						$display("%0t: mean_width expected %0d, got %0d",
							$time, exp_r.mean, mean_width);
					end
					if (level_code !== exp_r.code) begin
						fail_count++;
						$display("%0t: level_code expected %0d, got %0d (mean %0d)",
							$time, exp_r.code, level_code, exp_r.mean);
					end
				end
			end
			if (echo_valid && !echo_stall)
				predict_mean_and_code(echo_width);
		end
		pending = mean_code_queue.size();
	end

endmodule

/* tb/sv/tb_echo_average_distance_classifier.sv */
`timescale 1ns / 100ps
// Top of the echo average distance classifier testbench: clock, reset, register
// setup, echo request stimulus with bursts and gaps, result stall pattern and
// verdict. Depends on eadc_pkg, eadc_result_checker and the block under test.
module tb_echo_average_distance_classifier;
	import eadc_pkg::*;

	localparam int WINDOW_LEN = 10;
	localparam int NUM_PHASES = 9;
	localparam int REQS_PER_PHASE = 150;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_BLOCKS
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        echo_valid = 1'b0;
	logic        echo_stall;
	logic [15:0] echo_width = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [15:0] mean_width;
	logic [2:0]  level_code;

	int          fail_count;
	int          pending;
	int          checked;

	int          sent = 0;
	int          burst_left = 0;
	int          center = 0;
	int          run_left = 0;
	band_cfg_t   cfg_now;

	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	echo_average_distance_classifier #(.WINDOW_LEN(WINDOW_LEN)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.echo_valid(echo_valid), .echo_stall(echo_stall), .echo_width(echo_width),
		.result_valid(result_valid), .result_stall(result_stall),
		.mean_width(mean_width), .level_code(level_code)
	);

	eadc_result_checker #(.WINDOW_LEN(WINDOW_LEN)) u_chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.echo_valid(echo_valid), .echo_stall(echo_stall), .echo_width(echo_width),
		.result_valid(result_valid), .result_stall(result_stall),
		.mean_width(mean_width), .level_code(level_code),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	always #5 clk = ~clk;

	// Receiver stall: modes held for random stretches, including no stall at all
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(20, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  result_stall <= 1'b0;
			STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
			default:     result_stall <= stall_left[2];
		endcase
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Two-phase register write; lands at the access edge
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_limits(logic [31:0] mode, logic [31:0] far_cm,
		logic [31:0] mid_cm, logic [31:0] near_cm);
		write_reg(REG_BAND_MODE, mode);
		write_reg(REG_FAR_LIMIT, far_cm);
		write_reg(REG_MID_LIMIT, mid_cm);
		write_reg(REG_NEAR_LIMIT, near_cm);
		cfg_now.band_mode = mode[0];
		cfg_now.far_limit_cm = far_cm[7:0];
		cfg_now.mid_limit_cm = mid_cm[7:0];
		cfg_now.near_limit_cm = near_cm[7:0];
	endtask

	// Hold requests until every result is back, then let the pipeline settle
	task automatic drain();
		echo_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (6) @(posedge clk);
	endtask

	// One echo request; afterwards either keep the burst going or open a gap
	task automatic send_echo(logic [15:0] w);
		int gap;
		echo_valid <= 1'b1;
		echo_width <= w;
		do @(posedge clk); while (echo_stall);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 24);
			echo_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 40);
		end
	endtask

	// Runs of similar widths so the mean settles near band edges, plus noise
	function automatic logic [15:0] next_width();
		int edges [10];
		int w;
		edges = '{int'(EIGHT_FAR_US), int'(EIGHT_B1_US), int'(EIGHT_B2_US),
			int'(EIGHT_B3_US), int'(EIGHT_B4_US), int'(EIGHT_B5_US), int'(EIGHT_B6_US),
			int'(cfg_now.far_limit_cm) * int'(US_PER_CM),
			int'(cfg_now.mid_limit_cm) * int'(US_PER_CM),
			int'(cfg_now.near_limit_cm) * int'(US_PER_CM)};
		if (run_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: center = edges[$urandom_range(0, 9)] +
					int'($urandom_range(0, 10)) - 5;
				5, 6:    center = $urandom_range(0, 3000);
				7:       center = $urandom_range(0, 65535);
				8:       center = 0;
				default: center = 65535;
			endcase
			run_left = $urandom_range(5, 25);
		end
		run_left--;
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		w = center + int'($urandom_range(0, 6)) - 3;
		if (w < 0) w = 0;
		if (w > 65535) w = 65535;
		return 16'(w);
	endfunction

	initial begin
		logic [15:0] directed [25];
		int near_cm;
		int mid_cm;
		int far_cm;

		// full-scale window, then decay to zero, then a few edge values
		for (int i = 0; i < 10; i++) directed[i] = 16'hFFFF;
		for (int i = 10; i < 20; i++) directed[i] = 16'h0000;
		directed[20] = EIGHT_B6_US;
		directed[21] = EIGHT_FAR_US;
		directed[22] = EIGHT_FAR_US - 16'd1;
		directed[23] = 16'd1;
		directed[24] = 16'h8000;

		cfg_now.band_mode = 1'b0;
		cfg_now.far_limit_cm = 8'd20;
		cfg_now.mid_limit_cm = 8'd15;
		cfg_now.near_limit_cm = 8'd10;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_echo(directed[i]);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain();
			case (phase)
				0: load_limits(0, 20, 15, 10);
				1: load_limits(1, 20, 15, 10);
				2: begin
					// properly ordered limits
					near_cm = $urandom_range(0, 80);
					mid_cm = near_cm + $urandom_range(1, 80);
					far_cm = mid_cm + $urandom_range(1, 95);
					load_limits(1, far_cm, mid_cm, near_cm);
				end
				3: begin
					// reversed limits
					far_cm = $urandom_range(0, 80);
					mid_cm = far_cm + $urandom_range(1, 80);
					near_cm = mid_cm + $urandom_range(1, 95);
					load_limits(1, far_cm, mid_cm, near_cm);
				end
				4: load_limits(1, 0, 0, 0);
				5: load_limits(1, 255, 255, 255);
				6: load_limits($urandom | 32'h1, $urandom, $urandom, $urandom);
				7: load_limits(32'hFFFF_FFFE, $urandom, $urandom, $urandom);
				default: load_limits(1, 255, 255, 0);
			endcase
			run_left = 0;
			for (int i = 0; i < REQS_PER_PHASE; i++) send_echo(next_width());
		end

		echo_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (10) @(posedge clk);

		$display("Sent %0d echo widths under %0d register settings; %0d results compared.",
			sent, NUM_PHASES + 1, checked);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
